// ----- hw/rtl/lru_key_value_cache_core_defines.svh -----
// Assertion macros shared by the LRU key-value cache RTL.
// Depends on nothing; files that assert include it by name.
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// Check a property on every rising clk edge outside reset.
`define LKV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clk edge outside reset.
`define LKV_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/lkv_pkg.sv -----
// Package for the LRU key-value cache: sizes, operation codes and payload types.
// Depends on nothing; used by lkv_tags, the core RTL and the testbench.
package lkv_pkg;

	localparam int ENTRIES    = 16;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int CAP_W      = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Operation codes
	localparam logic [1:0] FUNC_GET    = 2'd0;
	localparam logic [1:0] FUNC_PUT    = 2'd1;
	localparam logic [1:0] FUNC_REMOVE = 2'd2;

	typedef struct packed {
		logic [1:0]            func;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		logic                  hit;
		logic [VALUE_BITS-1:0] read_value;
		logic                  evicted;
		logic [4:0]            occupancy;
	} rsp_t;

	// Lookup decision from the tag array to the control path
	typedef struct packed {
		logic             hit;
		logic             evicted;
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic [CNT_W-1:0] occupancy;
	} look_t;

endpackage

// ----- hw/rtl/lkv_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module lkv_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, data registered and valid in the cycle after the address
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/lkv_tags.sv -----
// Key match array with valid bits, recency ranks and entry count for the LRU cache.
// Depends on lkv_pkg; decides hit, eviction and slot, and applies the update on commit.
module lkv_tags import lkv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             commit,
	input  req_t             req,
	input  logic [CAP_W-1:0] capacity,
	output look_t            look
);

	logic [ENTRIES-1:0]  valid_q;
	logic [KEY_BITS-1:0] key_q [ENTRIES];
	logic [IDX_W-1:0]    rank_q [ENTRIES];
	logic [CNT_W-1:0]    count_q;

	logic [ENTRIES-1:0] match;
	logic               found, victim_ok, free_ok;
	logic [IDX_W-1:0]   found_idx, victim_idx, free_idx, slot_idx, found_rank, last_rank;
	logic [CNT_W-1:0]   count_m1, eff_cap;
	logic               is_get, is_put, is_rem, need_evict;
	logic               do_touch, do_remove, do_evict, do_insert;

	assign is_get = (req.func == FUNC_GET);
	assign is_put = (req.func == FUNC_PUT);
	assign is_rem = (req.func == FUNC_REMOVE);

	// Compare the key against every entry and pick the lowest match, victim and free slot
	assign count_m1  = count_q - CNT_W'(1);
	assign last_rank = count_m1[IDX_W-1:0];

	always_comb begin
		match      = '0;
		found      = 1'b0;
		found_idx  = '0;
		victim_ok  = 1'b0;
		victim_idx = '0;
		free_ok    = 1'b0;
		free_idx   = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (key_q[i] == req.key);
			if (match[i]) begin
				found     = 1'b1;
				found_idx = IDX_W'(i);
			end
			if (valid_q[i] && (rank_q[i] == last_rank)) begin
				victim_ok  = 1'b1;
				victim_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_ok  = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	assign found_rank = rank_q[found_idx];

	// Clamp the capacity to 1..ENTRIES
	always_comb begin
		if (capacity == '0) begin
			eff_cap = CNT_W'(1);
		end else if (capacity > CAP_W'(ENTRIES)) begin
			eff_cap = CNT_W'(ENTRIES);
		end else begin
			eff_cap = CNT_W'(capacity);
		end
	end

	assign need_evict = (count_q >= eff_cap) && (count_q != '0);

	// Decide the operation
	assign do_touch  = (is_get || is_put) && found;
	assign do_remove = is_rem && found;
	assign do_evict  = is_put && !found && need_evict && victim_ok;
	assign do_insert = is_put && !found && !do_evict && free_ok;
	assign slot_idx  = do_evict ? victim_idx : free_idx;

	always_comb begin
		look.hit       = found && (is_get || is_put || is_rem);
		look.evicted   = do_evict;
		look.rd_en     = is_get && found;
		look.rd_idx    = found_idx;
		look.wr_en     = (is_put && found) || do_evict || do_insert;
		look.wr_idx    = found ? found_idx : slot_idx;
		look.occupancy = count_q + CNT_W'(do_insert) - CNT_W'(do_remove);
	end

	// Update valid bits, ranks and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int j = 0; j < ENTRIES; j++) begin
				rank_q[j] <= '0;
			end
		end else if (commit) begin
			count_q <= look.occupancy;
			for (int j = 0; j < ENTRIES; j++) begin
				if (do_touch && valid_q[j]) begin
					if (IDX_W'(j) == found_idx) begin
						rank_q[j] <= '0;
					end else if (rank_q[j] < found_rank) begin
						rank_q[j] <= rank_q[j] + IDX_W'(1);
					end
				end
				if (do_remove && valid_q[j]) begin
					if (IDX_W'(j) == found_idx) begin
						valid_q[j] <= 1'b0;
					end else if (rank_q[j] > found_rank) begin
						rank_q[j] <= rank_q[j] - IDX_W'(1);
					end
				end
				if (do_evict || do_insert) begin
					if (IDX_W'(j) == slot_idx) begin
						valid_q[j] <= 1'b1;
						rank_q[j]  <= '0;
					end else if (valid_q[j]) begin
						rank_q[j] <= rank_q[j] + IDX_W'(1);
					end
				end
			end
		end
	end

	// Capture the key into the new slot
	always_ff @(posedge clk) begin
		if (commit && (do_evict || do_insert)) begin
			key_q[slot_idx] <= req.key;
		end
	end

endmodule

// ----- hw/rtl/lru_key_value_cache_core.sv -----
// LRU key-value cache core: a request is accepted, then goes through tag lookup and update with value
// RAM access, then response capture from the RAM's registered read data, which waits while an earlier
// response is held. A new request is taken only after the previous response has been captured.
// The response register frees the input side while a response waits.
// Reset: all entries invalid, occupancy 0, capacity 16; the value RAM is not cleared.
module lru_key_value_cache_core import lkv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	`include "lru_key_value_cache_core_defines.svh"

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	state_t                state_q;
	req_t                  req_s1;
	look_t                 look;
	logic [CAP_W-1:0]      capacity_q;
	logic                  hit_s2, ev_s2, get_s2;
	logic [CNT_W-1:0]      occ_s2;
	logic [VALUE_BITS-1:0] rd_data;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;
	logic                  commit, load_rsp;

	assign req_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign commit    = (state_q == ST_LOOK);
	assign load_rsp  = (state_q == ST_RESP) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Hold the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	lkv_tags u_tags (
		.clk      (clk),
		.arst_n   (arst_n),
		.commit   (commit),
		.req      (req_s1),
		.capacity (capacity_q),
		.look     (look)
	);

	lkv_ram #(
		.DEPTH (ENTRIES),
		.WIDTH (VALUE_BITS)
	) u_values (
		.clk     (clk),
		.wr_en   (commit && look.wr_en),
		.wr_addr (look.wr_idx),
		.wr_data (req_s1.value),
		.rd_en   (commit && look.rd_en),
		.rd_addr (look.rd_idx),
		.rd_data (rd_data)
	);

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_LOOK;
				end
				ST_LOOK: state_q <= ST_RESP;
				ST_RESP: begin
					if (load_rsp) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the accepted transaction and the lookup outcome
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (commit) begin
			hit_s2 <= look.hit;
			ev_s2  <= look.evicted;
			get_s2 <= look.rd_en;
			occ_s2 <= look.occupancy;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q.hit        <= hit_s2;
			rsp_q.read_value <= get_s2 ? rd_data : '0;
			rsp_q.evicted    <= ev_s2;
			rsp_q.occupancy  <= 5'(occ_s2);
		end
	end

	`LKV_NEVER(a_evict_on_hit, rsp_valid && rsp.evicted && rsp.hit, "eviction reported on a hit")
	`LKV_NEVER(a_value_no_hit, rsp_valid && !rsp.hit && (rsp.read_value != '0), "value on a miss")
	`LKV_NEVER(a_occ_range, rsp_valid && (rsp.occupancy > 5'(ENTRIES)), "occupancy above entries")
	`LKV_ASSERT(a_look_resp, commit |=> (state_q == ST_RESP) && !req_ready, "lookup not followed by response")

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for lru_key_value_cache_core: directed and random get, put and remove
// traffic checked against an in-bench LRU model, with capacity changes and back-pressure.
// Depends on lkv_pkg and the core RTL only.
`timescale 1ns / 100ps

module testbench;
	import lkv_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int POOL_SIZE      = 32;
	localparam int PHASE_ITEMS    = 200;
	localparam int CAP_STEPS      = 10;
	localparam int LONG_HOLD      = 60;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PRINT_LIMIT    = 30;

	// LRU cache model and store of predicted responses
	class lru_scoreboard;
		bit              slot_used[ENTRIES];
		logic [31:0]     slot_key[ENTRIES];
		logic [31:0]     slot_value[ENTRIES];
		int unsigned     slot_rank[ENTRIES];
		int unsigned     used_count;
		logic [CAP_W-1:0] capacity;
		rsp_t            expected_q[$];
		int              errors;
		int              checked;
		int              hits_seen;
		int              evictions_seen;

		function void reset_state();
			for (int i = 0; i < ENTRIES; i++) begin
				slot_used[i] = 1'b0;
				slot_rank[i] = 0;
			end
			used_count = 0;
			capacity = CAP_RESET;
			expected_q.delete();
		endfunction

		function void set_capacity(logic [CAP_W-1:0] cap);
			capacity = cap;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Make slot most recent; age the entries that were more recent
		function void promote(int idx);
			for (int j = 0; j < ENTRIES; j++)
				if (slot_used[j] && slot_rank[j] < slot_rank[idx])
					slot_rank[j]++;
			slot_rank[idx] = 0;
		endfunction

		// Free slot; entries that were less recent move up one rank
		function void free_slot(int idx);
			slot_used[idx] = 1'b0;
			for (int j = 0; j < ENTRIES; j++)
				if (slot_used[j] && slot_rank[j] > slot_rank[idx])
					slot_rank[j]--;
			if (used_count > 0)
				used_count--;
		endfunction

		// Predict the response of one accepted request and update the model
		function void note_request(req_t r);
			rsp_t        e;
			int          found;
			int          slot;
			int unsigned cap_eff;
			e = '0;
			found = -1;
			for (int i = 0; i < ENTRIES; i++)
				if (slot_used[i] && slot_key[i] == r.key) begin
					found = i;
					break;
				end
			case (r.func)
				FUNC_GET: begin
					if (found >= 0) begin
						e.hit = 1'b1;
						e.read_value = slot_value[found];
						promote(found);
					end
				end
				FUNC_PUT: begin
					if (found >= 0) begin
						e.hit = 1'b1;
						slot_value[found] = r.value;
						promote(found);
					end else begin
						slot = -1;
						cap_eff = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : capacity);
						// Drop the least recent entry when over capacity and reuse its slot
						if (used_count + 1 > cap_eff && used_count > 0) begin
							for (int i = 0; i < ENTRIES; i++)
								if (slot_used[i] && slot_rank[i] == used_count - 1) begin
									slot = i;
									break;
								end
							if (slot >= 0) begin
								free_slot(slot);
								e.evicted = 1'b1;
							end
						end
						if (slot < 0)
							for (int i = 0; i < ENTRIES; i++)
								if (!slot_used[i]) begin
									slot = i;
									break;
								end
						if (slot >= 0) begin
							for (int j = 0; j < ENTRIES; j++)
								if (slot_used[j])
									slot_rank[j]++;
							slot_used[slot] = 1'b1;
							slot_key[slot] = r.key;
							slot_value[slot] = r.value;
							slot_rank[slot] = 0;
							used_count++;
						end
					end
				end
				FUNC_REMOVE: begin
					if (found >= 0) begin
						e.hit = 1'b1;
						free_slot(found);
					end
				end
				default: ;
			endcase
			e.occupancy = 5'(used_count);
			expected_q.insert(expected_q.size(), e);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_LIMIT)
				$display("MISMATCH @%0t: %s", $time, msg);
		endtask

		// Compare one accepted response with the oldest prediction
		task check_response(rsp_t got);
			rsp_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("response with nothing outstanding (%h)", got));
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.hit !== want.hit)
				report($sformatf("hit got %b want %b", got.hit, want.hit));
			if (got.read_value !== want.read_value)
				report($sformatf("read_value got %h want %h", got.read_value, want.read_value));
			if (got.evicted !== want.evicted)
				report($sformatf("evicted got %b want %b", got.evicted, want.evicted));
			if (got.occupancy !== want.occupancy)
				report($sformatf("occupancy got %0d want %0d", got.occupancy, want.occupancy));
			if (want.hit)
				hits_seen++;
			if (want.evicted)
				evictions_seen++;
		endtask

		task check_leftovers();
			if (expected_q.size() != 0)
				report($sformatf("%0d responses never arrived", expected_q.size()));
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	req_t             req = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	rsp_t             rsp;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data = '0;

	lru_scoreboard    sb;
	logic [31:0]      key_pool[POOL_SIZE];
	logic [CAP_W-1:0] cap_plan[CAP_STEPS];
	bit               sender_gaps_on = 1'b1;
	bit               receiver_stalls_on = 1'b1;
	bit               long_hold = 1'b0;
	int               idle_cycles = 0;
	int               sent = 0;
	int               cap_writes = 0;

	lru_key_value_cache_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Check every response transaction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_response(rsp);
	end

	// End the run when no transaction completes for too long
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", idle_cycles);
			$display("testbench: errors");
			$finish;
		end
	end

	// Drive rsp_ready: random stall bursts and one long hold
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold) begin
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
				rsp_ready <= 1'b1;
			end else if (receiver_stalls_on && $urandom_range(0, 3) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Offer one request and hold it until accepted; valid stays high afterward
	task automatic send_request(input req_t item);
		if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		sb.note_request(item);
		sent++;
	endtask

	task automatic send_op(input logic [1:0] func, input logic [31:0] key,
			input logic [31:0] value);
		req_t item;
		item.func = func;
		item.key = key;
		item.value = value;
		send_request(item);
	endtask

	// Stop offering and wait for every predicted response
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		do @(posedge clk); while (!cfg_ready);
		sb.set_capacity(cap);
		cfg_valid <= 1'b0;
		cap_writes++;
	endtask

	// Random request: mostly pool keys so that hits and evictions happen
	function automatic req_t make_request(input int span);
		req_t r;
		int   pick;
		pick = $urandom_range(0, 99);
		if (pick < 38)
			r.func = FUNC_GET;
		else if (pick < 80)
			r.func = FUNC_PUT;
		else if (pick < 96)
			r.func = FUNC_REMOVE;
		else
			r.func = FUNC_UNUSED;
		if ($urandom_range(0, 9) == 0)
			r.key = $urandom();
		else
			r.key = key_pool[$urandom_range(0, span - 1)];
		r.value = $urandom();
		return r;
	endfunction

	initial begin
		int span;
		sb = new;
		sb.reset_state();
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom();
		cap_plan = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd7, 5'd12, 5'd3, 5'd17, 5'd16, 5'd0};
		cap_plan[CAP_STEPS-1] = $urandom_range(0, 31);

		// Hold reset, then release it
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty store, extremes of key and value, unused code
		send_op(FUNC_GET, 32'h0000_0000, 32'h0);
		send_op(FUNC_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(FUNC_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF);
		send_op(FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_op(FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
		send_op(FUNC_GET, 32'h0000_0000, 32'h0);
		send_op(FUNC_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(FUNC_PUT, 32'h0000_0000, 32'h1234_5678);
		send_op(FUNC_GET, 32'h0000_0000, 32'h0);
		send_op(FUNC_UNUSED, 32'h0000_0000, 32'hA5A5_5A5A);
		send_op(FUNC_REMOVE, 32'h0000_0000, 32'h0);
		send_op(FUNC_REMOVE, 32'h0000_0000, 32'h0);
		send_op(FUNC_GET, 32'h0000_0000, 32'h0);

		// Directed: small capacity, eviction of the least recent entry
		wait_drained();
		write_capacity(5'd2);
		send_op(FUNC_PUT, 32'h0000_0001, 32'h1111_1111);
		send_op(FUNC_PUT, 32'h0000_0002, 32'h2222_2222);
		send_op(FUNC_GET, 32'h0000_0001, 32'h0);
		send_op(FUNC_PUT, 32'h0000_0003, 32'h3333_3333);
		send_op(FUNC_GET, 32'h0000_0002, 32'h0);
		send_op(FUNC_GET, 32'h0000_0001, 32'h0);

		// Directed: capacity lowered below occupancy, occupancy holds
		wait_drained();
		write_capacity(5'd1);
		send_op(FUNC_PUT, 32'h0000_0004, 32'h4444_4444);
		send_op(FUNC_PUT, 32'h0000_0005, 32'h5555_5555);
		send_op(FUNC_GET, 32'h0000_0003, 32'h0);
		send_op(FUNC_REMOVE, 32'h0000_0005, 32'h0);

		// Random phases, one capacity setting each
		for (int p = 0; p < CAP_STEPS; p++) begin
			wait_drained();
			write_capacity(cap_plan[p]);
			if (p == 2)
				long_hold = 1'b1;
			if (p == 5) begin
				sender_gaps_on = 1'b0;
				receiver_stalls_on = 1'b0;
			end else if (p == 6) begin
				sender_gaps_on = 1'b1;
				receiver_stalls_on = 1'b1;
			end
			if (p == CAP_STEPS - 1) begin
				sender_gaps_on = 1'b0;
				receiver_stalls_on = 1'b0;
			end
			span = $urandom_range(4, POOL_SIZE);
			repeat (PHASE_ITEMS) send_request(make_request(span));
		end

		// Drain, then give the pipeline time to show any stray response
		wait_drained();
		repeat (8) @(posedge clk);
		sb.check_leftovers();

		$display("summary: %0d requests sent, %0d responses checked, %0d capacity writes",
			sent, sb.checked, cap_writes);
		$display("summary: %0d hits, %0d evictions, %0d mismatches",
			sb.hits_seen, sb.evictions_seen, sb.errors);
		if (sb.errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
